// ===== design/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

    // Widths of the message byte, the hash word and the message length
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [4:0][WORD_W-1:0] chain_t;
    typedef logic [15:0][WORD_W-1:0] window_t;

    // Initial chaining values
    localparam word_t IV0 = 32'h67452301;
    localparam word_t IV1 = 32'hEFCDAB89;
    localparam word_t IV2 = 32'h98BADCFE;
    localparam word_t IV3 = 32'h10325476;
    localparam word_t IV4 = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds
    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [BYTE_W-1:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [BYTE_W-1:0] PAD_ZERO_BYTE = 8'h00;

    // Round counter and block fill points
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [6:0] ROUND_GRP1   = 7'd20;
    localparam logic [6:0] ROUND_GRP2   = 7'd40;
    localparam logic [6:0] ROUND_GRP3   = 7'd60;
    localparam logic [5:0] LAST_FILL    = 6'd63;
    localparam logic [5:0] LEN_FILL     = 6'd56;
    localparam logic [2:0] LAST_LEN_IDX = 3'd7;
    localparam logic [2:0] LAST_WORD    = 3'd4;
    localparam logic [LEN_W-1:0] BITS_PER_BYTE = 64'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } core_state_t;

    // Controls from the sequencer to the compression core
    typedef struct packed {
        logic                push;
        logic [BYTE_W-1:0]   push_byte;
        logic                start;
        logic                init;
    } core_ctrl_t;

    // Status back from the compression core
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic word_t rotl1(input word_t x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

    // Round function, selected by round group
    function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        if (rnd < ROUND_GRP1)
        begin
            round_f = (b & c) | (~b & d);
        end
        else if (rnd < ROUND_GRP2)
        begin
            round_f = b ^ c ^ d;
        end
        else if (rnd < ROUND_GRP3)
        begin
            round_f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            round_f = b ^ c ^ d;
        end
    endfunction

    function automatic word_t round_k(input logic [6:0] rnd);
        if (rnd < ROUND_GRP1)
        begin
            round_k = K0;
        end
        else if (rnd < ROUND_GRP2)
        begin
            round_k = K1;
        end
        else if (rnd < ROUND_GRP3)
        begin
            round_k = K2;
        end
        else
        begin
            round_k = K3;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/sha1_in_if.sv =====
`default_nettype none

// Message channel: at most one byte per transfer plus flags
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (
        output valid,
        output data_byte,
        output byte_present,
        output end_of_message,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  byte_present,
        input  end_of_message,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/sha1_out_if.sv =====
`default_nettype none

// Digest channel: one 32-bit digest word per transfer
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source (
        output valid,
        output digest_word,
        output word_number,
        output final_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  digest_word,
        input  word_number,
        input  final_word,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/sha1_core.sv =====
`default_nettype none

// Compression core: byte gather window, one round per cycle, chaining words.
// The 16-word window doubles as the block buffer while bytes are pushed in.
module sha1_core
    import sha1_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire core_ctrl_t ctrl,
    output core_stat_t      stat,
    output chain_t          chain
);

    core_state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    window_t     window_reg, window_next;
    chain_t      chain_reg, chain_next;
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t       a_next, b_next, c_next, d_next, e_next;
    word_t       sched_word;
    word_t       temp_word;

    // Schedule expansion and round sum
    assign sched_word = rotl1(window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0]);
    assign temp_word  = rotl5(a_reg) + round_f(round_reg, b_reg, c_reg, d_reg) + e_reg
                      + round_k(round_reg) + window_reg[0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CORE_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = CORE_ADD;
                end
            end
            CORE_ADD:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    // Status
    always_comb
    begin
        stat.busy = (state_reg != CORE_IDLE);
        stat.done = (state_reg == CORE_ADD);
    end

    // Window: byte shift while gathering, word shift while running rounds.
    // The start push and the window load happen in the same cycle.
    always_comb
    begin
        window_next = window_reg;
        if (ctrl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = {window_reg[i][23:0], window_reg[i+1][31:24]};
            end
            window_next[15] = {window_reg[15][23:0], ctrl.push_byte};
        end
        else if (state_reg == CORE_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i+1];
            end
            window_next[15] = sched_word;
        end
    end

    // Working variables and round counter
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        round_next = round_reg;
        if (state_reg == CORE_IDLE && ctrl.start)
        begin
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            e_next     = chain_reg[4];
            round_next = '0;
        end
        else if (state_reg == CORE_ROUND)
        begin
            a_next     = temp_word;
            b_next     = a_reg;
            c_next     = rotl30(b_reg);
            d_next     = c_reg;
            e_next     = d_reg;
            round_next = round_reg + 7'd1;
        end
    end

    // Chaining words: feed-forward add at block end, initial values per message
    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.init)
        begin
            chain_next = {IV4, IV3, IV2, IV1, IV0};
        end
        else if (state_reg == CORE_ADD)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    assign chain = chain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            round_reg <= '0;
            chain_reg <= {IV4, IV3, IV2, IV1, IV0};
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
    end

endmodule

`default_nettype wire

// ===== design/sha1_message_digest_top.sv =====
`default_nettype none

// SHA-1 digest of a byte stream. Each msg transfer carries at most one byte;
// end_of_message marks the last transfer (which may carry no byte, so an empty
// message is allowed). msg.ready is high while a block fills; the transfer
// that completes a 64-byte block is followed by the block's 80 rounds on the
// single shared round adder and one feed-forward add, during which msg.ready is
// low. After the last transfer the block pads one byte per cycle (held while
// rounds run) up to the 64-byte boundary, pausing once before the eight length
// bytes (one or two extra blocks, each again run through the rounds), then
// offers the five digest words, H0 first, one per digest transfer, and returns
// to the initial state.
module sha1_message_digest_top
    import sha1_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sha1_in_if.sink    msg,
    sha1_out_if.source digest
);

    top_state_t        state_reg, state_next;
    top_state_t        resume_reg, resume_next;
    top_state_t        after_push;
    logic [5:0]        fill_reg;
    logic [2:0]        len_idx_reg;
    logic [2:0]        word_reg;
    logic [LEN_W-1:0]  bit_count_reg;
    logic              msg_xfer;
    logic              digest_xfer;
    core_ctrl_t        core_ctrl;
    core_stat_t        core_stat;
    chain_t            chain;

    sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .stat  (core_stat),
        .chain (chain)
    );

    assign msg_xfer    = msg.valid && msg.ready;
    assign digest_xfer = digest.valid && digest.ready;

    // Outputs: handshakes, byte pushes into the core, digest payload
    always_comb
    begin
        msg.ready           = (state_reg == ST_IDLE);
        digest.valid        = (state_reg == ST_OUT);
        core_ctrl.push      = 1'b0;
        core_ctrl.push_byte = PAD_ZERO_BYTE;
        case (state_reg)
            ST_IDLE:
            begin
                core_ctrl.push      = msg_xfer && msg.byte_present;
                core_ctrl.push_byte = msg.data_byte;
            end
            ST_PAD_MARK:
            begin
                core_ctrl.push      = 1'b1;
                core_ctrl.push_byte = PAD_MARK_BYTE;
            end
            ST_PAD_ZERO:
            begin
                core_ctrl.push = (fill_reg != LEN_FILL);
            end
            ST_PAD_LEN:
            begin
                core_ctrl.push      = 1'b1;
                core_ctrl.push_byte = bit_count_reg[LEN_W-1 -: BYTE_W];
            end
            default:
            begin
                core_ctrl.push = 1'b0;
            end
        endcase
        core_ctrl.start = core_ctrl.push && (fill_reg == LAST_FILL);
        core_ctrl.init  = digest_xfer && (word_reg == LAST_WORD);

        case (word_reg)
            3'd1:    digest.digest_word = chain[1];
            3'd2:    digest.digest_word = chain[2];
            3'd3:    digest.digest_word = chain[3];
            3'd4:    digest.digest_word = chain[4];
            default: digest.digest_word = chain[0];
        endcase
        digest.word_number = word_reg;
        digest.final_word  = (word_reg == LAST_WORD);
    end

    // Next state: a push that fills the block detours through the rounds
    always_comb
    begin
        after_push  = state_reg;
        state_next  = state_reg;
        resume_next = resume_reg;
        case (state_reg)
            ST_IDLE:
            begin
                after_push = (msg_xfer && msg.end_of_message) ? ST_PAD_MARK : ST_IDLE;
            end
            ST_PAD_MARK:
            begin
                after_push = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                after_push = (fill_reg == LEN_FILL) ? ST_PAD_LEN : ST_PAD_ZERO;
            end
            ST_PAD_LEN:
            begin
                after_push = (len_idx_reg == LAST_LEN_IDX) ? ST_OUT : ST_PAD_LEN;
            end
            ST_ROUND:
            begin
                after_push = core_stat.done ? resume_reg : ST_ROUND;
            end
            ST_OUT:
            begin
                after_push = core_ctrl.init ? ST_IDLE : ST_OUT;
            end
            default:
            begin
                after_push = ST_IDLE;
            end
        endcase

        if (core_ctrl.start)
        begin
            state_next  = ST_ROUND;
            resume_next = after_push;
        end
        else
        begin
            state_next = after_push;
        end
    end

    // Fill count, length bytes, bit length, digest word index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            resume_reg    <= ST_IDLE;
            fill_reg      <= '0;
            len_idx_reg   <= '0;
            word_reg      <= '0;
            bit_count_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            if (core_ctrl.push)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (state_reg == ST_PAD_LEN)
            begin
                len_idx_reg   <= len_idx_reg + 3'd1;
                bit_count_reg <= {bit_count_reg[LEN_W-BYTE_W-1:0], PAD_ZERO_BYTE};
            end
            else if (core_ctrl.init)
            begin
                bit_count_reg <= '0;
            end
            else if (msg_xfer && msg.byte_present)
            begin
                bit_count_reg <= bit_count_reg + BITS_PER_BYTE;
            end
            if (core_ctrl.init)
            begin
                word_reg <= '0;
            end
            else if (digest_xfer)
            begin
                word_reg <= word_reg + 3'd1;
            end
        end
    end

    // The core must be idle whenever a byte can be pushed or a word is shown
    a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.ready || digest.valid) |-> !core_stat.busy)
        else $error("core busy while accepting bytes or offering digest");

    // Length bytes are always written into the last eight slots of a block
    a_len_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD_LEN) |-> (fill_reg[5:3] == LEN_FILL[5:3]))
        else $error("length bytes out of place");

    // Digest is only offered on a block boundary
    a_out_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (fill_reg == '0 && len_idx_reg == '0))
        else $error("digest offered mid block");

    // After the final digest word the block is back at its initial state
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.init |=> (state_reg == ST_IDLE && bit_count_reg == '0 && word_reg == '0))
        else $error("state not restored after digest");

endmodule

`default_nettype wire
